FILE: sv/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int unsigned DEFAULT_MAX_DIM = 8;

	localparam int unsigned IDX_W   = 3;   // row / col / k index width
	localparam int unsigned SIZE_W  = 4;   // matrix_size register width
	localparam int unsigned AB_W    = 16;  // Q8.8
	localparam int unsigned C_W     = 48;  // Q32.16
	localparam int unsigned PROD_W  = 2 * AB_W;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = SIZE_W'(8);

	// register word index, taken from paddr[2]
	localparam logic REG_MATRIX_SIZE = 1'b0;

	localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
	localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};
	localparam logic signed [C_W-1:0] Q88_MAX = C_W'(32767);
	localparam logic signed [C_W-1:0] Q88_MIN = -C_W'(32768);

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_LOAD_C  = 2'd2,
		ACT_COMPUTE = 2'd3
	} action_t;

	// load strobes, controller -> datapath
	typedef struct packed {
		logic we_a;
		logic we_b;
		logic we_c;
	} load_cmd_t;

	// one multiply-accumulate step, controller -> datapath
	typedef struct packed {
		logic             valid;
		logic             first;      // k == 0: seed from C
		logic             last_k;     // k == n-1: element done
		logic             last_elem;  // final element of the matrix
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] k;
	} mac_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
	} dp_status_t;

endpackage

FILE: sv/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: decodes requests and walks (i, j, k) during a compute.
// ----------------------------------------------------------------------------
module mma_ctrl import mma_pkg::*; #(
	parameter int unsigned MAX_DIM = DEFAULT_MAX_DIM
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	input  logic [SIZE_W-1:0] matrix_size,
	input  dp_status_t        status,
	output logic              busy,
	output load_cmd_t         load_cmd,
	output mac_cmd_t          mac_cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] i_q, j_q, k_q, nm1_q;
	logic [SIZE_W-1:0] n_eff;
	logic             accept;
	logic             k_end, j_end, i_end;

	always_comb begin
		if (matrix_size == '0) begin
			n_eff = SIZE_W'(1);
		end else if (matrix_size > SIZE_W'(MAX_DIM)) begin
			n_eff = SIZE_W'(MAX_DIM);
		end else begin
			n_eff = matrix_size;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign load_cmd.we_a = accept && (action == ACT_LOAD_A);
	assign load_cmd.we_b = accept && (action == ACT_LOAD_B);
	assign load_cmd.we_c = accept && (action == ACT_LOAD_C);

	assign k_end = (k_q == nm1_q);
	assign j_end = (j_q == nm1_q);
	assign i_end = (i_q == nm1_q);

	assign mac_cmd.valid     = (state_q == ST_RUN);
	assign mac_cmd.first     = (k_q == '0);
	assign mac_cmd.last_k    = k_end;
	assign mac_cmd.last_elem = i_end && j_end;
	assign mac_cmd.row       = i_q;
	assign mac_cmd.col       = j_q;
	assign mac_cmd.k         = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			nm1_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (action == ACT_COMPUTE)) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						nm1_q   <= IDX_W'(n_eff - SIZE_W'(1));
					end
				end
				ST_RUN: begin
					if (!k_end) begin
						k_q <= k_q + IDX_W'(1);
					end else begin
						k_q <= '0;
						if (!j_end) begin
							j_q <= j_q + IDX_W'(1);
						end else begin
							j_q <= '0;
							if (!i_end) begin
								i_q <= i_q + IDX_W'(1);
							end else begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/mma_datapath.sv
// ----------------------------------------------------------------------------
// mma_datapath
// Element stores and the three-stage multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module mma_datapath import mma_pkg::*; #(
	parameter int unsigned MAX_DIM = DEFAULT_MAX_DIM
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [IDX_W-1:0]        row,
	input  logic [IDX_W-1:0]        col,
	input  logic signed [C_W-1:0]   value,
	input  load_cmd_t               load_cmd,
	input  mac_cmd_t                mac_cmd,
	output dp_status_t              status,
	output logic                    out_valid,
	output logic [IDX_W-1:0]        out_row,
	output logic [IDX_W-1:0]        out_col,
	output logic signed [C_W-1:0]   out_value,
	output logic                    last
);

	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
	                                                input logic [IDX_W-1:0] c);
		return ADDR_W'(int'(r) * MAX_DIM + int'(c));
	endfunction

	logic signed [AB_W-1:0] mem_a [DEPTH];
	logic signed [AB_W-1:0] mem_b [DEPTH];
	logic signed [C_W-1:0]  mem_c [DEPTH];
	logic [DEPTH-1:0]       c_vld_q;

	logic                   ld_in_range;
	logic [ADDR_W-1:0]      ld_addr;
	logic signed [AB_W-1:0] ld_ab;

	// stage 1: registered store reads
	logic                   v_s1, first_s1, lastk_s1, laste_s1;
	logic [IDX_W-1:0]       row_s1, col_s1;
	logic signed [AB_W-1:0] a_s1, b_s1;
	logic signed [C_W-1:0]  c_s1;
	logic                   cv_s1;

	// stage 2: product
	logic                   v_s2, first_s2, lastk_s2, laste_s2;
	logic [IDX_W-1:0]       row_s2, col_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [C_W-1:0]  c_s2;

	// stage 3: accumulate
	logic signed [C_W-1:0]  acc_q;
	logic signed [C_W-1:0]  base;
	logic signed [C_W:0]    sum;
	logic signed [C_W-1:0]  sum_sat;
	logic                   wb;

	logic                   out_valid_q, last_q;
	logic [IDX_W-1:0]       out_row_q, out_col_q;
	logic signed [C_W-1:0]  out_value_q;

	// loads
	assign ld_in_range = ({1'b0, row} < (IDX_W + 1)'(MAX_DIM)) &&
	                     ({1'b0, col} < (IDX_W + 1)'(MAX_DIM));
	assign ld_addr     = cell_addr(row, col);

	always_comb begin
		if (value > Q88_MAX) begin
			ld_ab = AB_W'(Q88_MAX);
		end else if (value < Q88_MIN) begin
			ld_ab = AB_W'(Q88_MIN);
		end else begin
			ld_ab = AB_W'(value);
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd.we_a && ld_in_range) begin
			mem_a[ld_addr] <= ld_ab;
		end
		if (load_cmd.we_b && ld_in_range) begin
			mem_b[ld_addr] <= ld_ab;
		end
		if (load_cmd.we_c && ld_in_range) begin
			mem_c[ld_addr] <= value;
		end else if (wb) begin
			mem_c[cell_addr(row_s2, col_s2)] <= sum_sat;
		end
	end

	// C reads as zero until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_q <= '0;
		end else if (load_cmd.we_c && ld_in_range) begin
			c_vld_q[ld_addr] <= 1'b1;
		end else if (wb) begin
			c_vld_q[cell_addr(row_s2, col_s2)] <= 1'b1;
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		a_s1     <= mem_a[cell_addr(mac_cmd.row, mac_cmd.k)];
		b_s1     <= mem_b[cell_addr(mac_cmd.k, mac_cmd.col)];
		c_s1     <= mem_c[cell_addr(mac_cmd.row, mac_cmd.col)];
		cv_s1    <= c_vld_q[cell_addr(mac_cmd.row, mac_cmd.col)];
		first_s1 <= mac_cmd.first;
		lastk_s1 <= mac_cmd.last_k;
		laste_s1 <= mac_cmd.last_elem;
		row_s1   <= mac_cmd.row;
		col_s1   <= mac_cmd.col;
	end

	// stage 2
	always_ff @(posedge clk) begin
		prod_s2  <= a_s1 * b_s1;
		c_s2     <= cv_s1 ? c_s1 : '0;
		first_s2 <= first_s1;
		lastk_s2 <= lastk_s1;
		laste_s2 <= laste_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= mac_cmd.valid;
			v_s2 <= v_s1;
		end
	end

	// stage 3: saturating accumulate
	assign base = first_s2 ? c_s2 : acc_q;
	assign sum  = (C_W + 1)'(base) + (C_W + 1)'(prod_s2);

	always_comb begin
		if (sum[C_W] != sum[C_W-1]) begin
			sum_sat = sum[C_W] ? C_MIN : C_MAX;
		end else begin
			sum_sat = sum[C_W-1:0];
		end
	end

	assign wb = v_s2 && lastk_s2;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= sum_sat;
		end
		out_row_q   <= row_s2;
		out_col_q   <= col_s2;
		out_value_q <= sum_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= wb;
			last_q      <= wb && laste_s2;
		end
	end

	assign status.pipe_busy = v_s1 || v_s2;

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign last      = last_q;

endmodule

FILE: sv/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// C += A * B on square fixed-point matrices of up to MAX_DIM rows.
// ----------------------------------------------------------------------------
// A load request (action 0..2) is taken while busy is low and does not raise
// busy, so loads stream at one per cycle while no compute runs. A compute
// request holds busy high until its last result is out: a single 16x16
// multiplier and a 48-bit saturating adder do one product per cycle,
// walking k fastest, then column, then row, behind a three-stage pipeline
// (store read, multiply, accumulate). Results come out in row-major order,
// the last one in the final busy cycle; out_valid marks each for exactly
// one cycle and the receiver cannot stall, so it must take every one. last
// is high on the final element. C stays in place, so the next compute
// accumulates onto it. C reads as zero after reset through per-entry valid
// bits; A and B hold garbage until loaded.
// Change matrix_size only while busy is low.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate import mma_pkg::*; #(
	parameter int unsigned MAX_DIM = DEFAULT_MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            action,
	input  logic [IDX_W-1:0]      row,
	input  logic [IDX_W-1:0]      col,
	input  logic signed [C_W-1:0] value,
	// result channel
	output logic                  out_valid,
	output logic [IDX_W-1:0]      out_row,
	output logic [IDX_W-1:0]      out_col,
	output logic signed [C_W-1:0] out_value,
	output logic                  last,
	// APB configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	logic [SIZE_W-1:0] matrix_size_q;
	load_cmd_t         load_cmd;
	mac_cmd_t          mac_cmd;
	dp_status_t        status;

	// config register: word index in paddr[2], one register only
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? APB_DW'(matrix_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= MATRIX_SIZE_RESET;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == REG_MATRIX_SIZE)) begin
			matrix_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	mma_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.matrix_size (matrix_size_q),
		.status      (status),
		.busy        (busy),
		.load_cmd    (load_cmd),
		.mac_cmd     (mac_cmd)
	);

	mma_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.row       (row),
		.col       (col),
		.value     (value),
		.load_cmd  (load_cmd),
		.mac_cmd   (mac_cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.last      (last)
	);

endmodule

FILE: sv/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks on request/result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module mma_checker import mma_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [1:0]            action,
	input logic                  out_valid,
	input logic                  last
);

	// results only come while a compute holds the block
	a_result_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy)
		else $error("result strobe outside a compute");

	// a compute request makes the block busy
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_COMPUTE)) |=> busy)
		else $error("compute request did not raise busy");

	// a load request never stalls the next one
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action != ACT_COMPUTE)) |=> !busy && !out_valid)
		else $error("load request raised busy or a result");

	// last only tags a result, and no result comes directly behind it
	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> out_valid)
		else $error("last without a result");

	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |=> !out_valid)
		else $error("result after last");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.action    (action),
	.out_valid (out_valid),
	.last      (last)
);

FILE: dv/matrix_multiply_accumulate_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_tb
// Self-checking bench for the fixed-point C += A*B block.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver. The driver sends them
// in bursts with random gaps. Each accepted request goes through a local
// copy of the A/B/C stores. A compute pushes the emitted C elements, in
// row-major order, onto an expectation queue. The monitor pops that queue
// on every out_valid strobe and checks each field. matrix_size is written
// over APB only while the block is idle, and read back after each write.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_tb;
	import mma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_DIM     = DEFAULT_MAX_DIM;
	localparam int unsigned CELLS       = MAX_DIM * MAX_DIM;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RAND_ITEMS  = 30;
	localparam int unsigned SETTLE      = 8;   // cycles past the final result

	// one request as the driver presents it
	typedef struct {
		action_t                 act;
		logic [IDX_W-1:0]        r;
		logic [IDX_W-1:0]        c;
		logic signed [C_W-1:0]   v;
		bit                      drain;   // hold off until no result is pending
	} mac_req_t;

	// one emitted element of C
	typedef struct packed {
		logic [IDX_W-1:0]      r;
		logic [IDX_W-1:0]      c;
		logic signed [C_W-1:0] v;
		logic                  l;
	} c_elem_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            action = ACT_LOAD_A;
	logic [IDX_W-1:0]      row = '0;
	logic [IDX_W-1:0]      col = '0;
	logic signed [C_W-1:0] value = '0;
	logic                  out_valid;
	logic [IDX_W-1:0]      out_row;
	logic [IDX_W-1:0]      out_col;
	logic signed [C_W-1:0] out_value;
	logic                  last;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_AW-1:0]     paddr = '0;
	logic [APB_DW-1:0]     pwdata = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	matrix_multiply_accumulate #(.MAX_DIM(MAX_DIM)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .action(action), .row(row), .col(col), .value(value),
		.out_valid(out_valid), .out_row(out_row), .out_col(out_col),
		.out_value(out_value), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// local copy of the block's state
	// ------------------------------------------------------------------
	shortint          mat_a [CELLS];
	shortint          mat_b [CELLS];
	longint           mat_c [CELLS];
	logic [SIZE_W-1:0] size_reg = MATRIX_SIZE_RESET;

	mac_req_t pend_q [$];     // requests not yet presented
	c_elem_t  c_elem_q [$];   // C elements still to be emitted
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	initial begin
		for (int i = 0; i < CELLS; i++) begin
			mat_a[i] = 0;
			mat_b[i] = 0;
			mat_c[i] = 0;
		end
	end

	task automatic report(input string msg);
		$display("[%0t] ERROR: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// size 0 acts as 1, anything past MAX_DIM acts as MAX_DIM
	function automatic int unsigned dim_in_use();
		if (size_reg == 0) return 1;
		if (size_reg > MAX_DIM) return MAX_DIM;
		return size_reg;
	endfunction

	function automatic shortint sat_q88(input logic signed [C_W-1:0] v);
		if (v > C_W'(32767)) return 16'sh7fff;
		if (v < -C_W'(32768)) return -16'sh8000;
		return shortint'(v[AB_W-1:0]);
	endfunction

	function automatic longint sat_q3216(input longint v);
		if (v > longint'(C_MAX)) return longint'(C_MAX);
		if (v < longint'(C_MIN)) return longint'(C_MIN);
		return v;
	endfunction

	// Applies one accepted request to the local stores; a compute queues the
	// whole C matrix in use.
	task automatic apply_mac_request(input mac_req_t rq);
		int unsigned n;
		int unsigned idx;
		longint acc;
		c_elem_t e;
		idx = rq.r * MAX_DIM + rq.c;
		case (rq.act)
			ACT_LOAD_A: mat_a[idx] = sat_q88(rq.v);
			ACT_LOAD_B: mat_b[idx] = sat_q88(rq.v);
			ACT_LOAD_C: mat_c[idx] = longint'(rq.v);
			ACT_COMPUTE: begin
				n = dim_in_use();
				// products added in ascending k, saturating after each add
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++) begin
						acc = mat_c[i * MAX_DIM + j];
						for (int k = 0; k < n; k++)
							acc = sat_q3216(acc + longint'(mat_a[i * MAX_DIM + k]) *
								longint'(mat_b[k * MAX_DIM + j]));
						mat_c[i * MAX_DIM + j] = acc;
					end
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++) begin
						e.r = IDX_W'(i);
						e.c = IDX_W'(j);
						e.v = mat_c[i * MAX_DIM + j][C_W-1:0];
						e.l = (i == n - 1) && (j == n - 1);
						c_elem_q.push_back(e);
					end
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// driver: bursts of requests separated by random gaps
	// ------------------------------------------------------------------
	mac_req_t    cur_req;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (start && !busy)
			apply_mac_request(cur_req);
		if (!start || !busy) begin
			if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pend_q.size() != 0 && !(pend_q[0].drain && c_elem_q.size() != 0)) begin
				cur_req = pend_q.pop_front();
				start  <= 1'b1;
				action <= cur_req.act;
				row    <= cur_req.r;
				col    <= cur_req.c;
				value  <= cur_req.v;
				if (burst_left <= 1) begin
					// now and then a long run with no idle cycles
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else
					burst_left--;
			end else
				start <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// monitor: every strobe must match the oldest pending C element
	// ------------------------------------------------------------------
	c_elem_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (c_elem_q.size() == 0)
				report($sformatf("unexpected result row %0d col %0d value %0d last %0b",
					out_row, out_col, out_value, last));
			else begin
				want = c_elem_q.pop_front();
				if (out_row !== want.r)
					report($sformatf("out_row %0d, want %0d", out_row, want.r));
				if (out_col !== want.c)
					report($sformatf("out_col %0d, want %0d", out_col, want.c));
				if (out_value !== want.v)
					report($sformatf("out_value at (%0d,%0d) is %0d, want %0d",
						want.r, want.c, out_value, want.v));
				if (last !== want.l)
					report($sformatf("last at (%0d,%0d) is %0b, want %0b",
						want.r, want.c, last, want.l));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] ERROR: timeout, %0d requests and %0d results pending",
				$realtime, pend_q.size(), c_elem_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic queue_request(input action_t act, input int unsigned r, input int unsigned c,
		input logic signed [C_W-1:0] v, input bit drain = 1'b0);
		mac_req_t rq;
		rq.act = act;
		rq.r = IDX_W'(r);
		rq.c = IDX_W'(c);
		rq.v = v;
		rq.drain = drain;
		pend_q.push_back(rq);
	endtask

	// all requests taken, all results seen, then a short settle
	task automatic wait_idle();
		while (pend_q.size() != 0 || start || busy || c_elem_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write of matrix_size, then a read back; called at a clock edge
	task automatic set_size(input int unsigned sz);
		logic [APB_DW-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_MATRIX_SIZE, 2'b00};
		pwdata  <= APB_DW'(sz);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		size_reg = SIZE_W'(sz);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rd = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DW'(size_reg))
			report($sformatf("matrix_size reads %0d, want %0d", rd, size_reg));
	endtask

	// mix of Q8.8-sized values, saturating values and C extremes
	function automatic logic signed [C_W-1:0] rand_value();
		logic signed [C_W-1:0] v;
		logic [15:0] r16;
		r16 = 16'($urandom);
		case ($urandom_range(0, 7))
			0: v = C_W'({$urandom(), $urandom()});
			1: v = C_MAX - C_W'($urandom_range(0, 1 << 20));
			2: v = C_MIN + C_W'($urandom_range(0, 1 << 20));
			3: v = C_W'($urandom_range(0, 1024)) - C_W'(512);
			4: v = $urandom_range(0, 1) ? C_W'(32768 + $urandom_range(0, 4))
				: -C_W'(32769 + $urandom_range(0, 4));
			default: v = {{(C_W - 16){r16[15]}}, r16};
		endcase
		return v;
	endfunction

	initial begin : stim
		int unsigned rand_items;
		int unsigned n;
		int unsigned sz;
		int unsigned r;
		int unsigned c;
		action_t act;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: 1x1, input saturation, C saturation both ways ---
		set_size(1);
		queue_request(ACT_LOAD_A, 0, 0, C_MAX);                // clips to 32767
		queue_request(ACT_LOAD_B, 0, 0, C_MIN);                // clips to -32768
		// outside the size but inside the store: kept for later
		queue_request(ACT_LOAD_A, 7, 7, C_W'(32767));
		queue_request(ACT_LOAD_B, 7, 7, -C_W'(32768));
		queue_request(ACT_LOAD_C, 7, 7, C_MIN);
		queue_request(ACT_COMPUTE, 5, 3, rand_value());          // indices ignored
		queue_request(ACT_COMPUTE, 7, 7, C_MAX, 1'b1);           // accumulates, drained
		queue_request(ACT_LOAD_C, 0, 0, C_MAX - 1);
		queue_request(ACT_LOAD_A, 0, 0, C_W'(32768));
		queue_request(ACT_LOAD_B, 0, 0, C_W'(32767));
		queue_request(ACT_COMPUTE, 0, 0, '0);                    // clips high
		queue_request(ACT_LOAD_C, 0, 0, C_MIN + 5);
		queue_request(ACT_LOAD_A, 0, 0, -C_W'(32769));
		queue_request(ACT_COMPUTE, 0, 0, '1);                    // clips low
		queue_request(ACT_COMPUTE, 1, 2, rand_value());          // stays at the floor
		queue_request(ACT_LOAD_C, 0, 0, '0);
		queue_request(ACT_LOAD_A, 0, 0, C_W'(256));              // 1.0
		queue_request(ACT_LOAD_B, 0, 0, -C_W'(256));             // -1.0
		queue_request(ACT_COMPUTE, 3, 4, rand_value());
		wait_idle();

		// size 0 behaves as 1
		set_size(0);
		queue_request(ACT_COMPUTE, 7, 0, rand_value());
		wait_idle();

		// --- fill every A and B entry once at the largest setting ---
		set_size(15);
		for (int i = 0; i < MAX_DIM; i++)
			for (int j = 0; j < MAX_DIM; j++) begin
				queue_request(ACT_LOAD_A, i, j, rand_value());
				queue_request(ACT_LOAD_B, i, j, rand_value());
			end
		queue_request(ACT_COMPUTE, 0, 0, rand_value());
		queue_request(ACT_COMPUTE, 0, 0, rand_value(), 1'b1);
		wait_idle();

		// --- random phases: a size, then a few load runs each ending in a compute ---
		rand_items = 0;
		sz = MAX_DIM;
		while (rand_items < RAND_ITEMS) begin
			set_size(sz);
			n = dim_in_use();
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(0, 10)) begin
					act = action_t'($urandom_range(ACT_LOAD_A, ACT_LOAD_C));
					if ($urandom_range(0, 4) != 0) begin
						r = $urandom_range(0, n - 1);
						c = $urandom_range(0, n - 1);
					end else begin
						r = $urandom_range(0, MAX_DIM - 1);
						c = $urandom_range(0, MAX_DIM - 1);
					end
					queue_request(act, r, c, rand_value());
					rand_items++;
				end
				queue_request(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
					rand_value(), $urandom_range(0, 7) == 0);
				rand_items++;
			end
			wait_idle();
			// mostly small sizes, now and then the edges of the register
			case ($urandom_range(0, 9))
				0: sz = 0;
				1: sz = $urandom_range(MAX_DIM + 1, 15);
				2: sz = MAX_DIM;
				3, 4, 5: sz = $urandom_range(1, 2);
				default: sz = $urandom_range(3, 5);
			endcase
		end

		while (pend_q.size() != 0 || start || busy || c_elem_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: matrix_multiply_accumulate.f
sv/mma_pkg.sv
sv/mma_ctrl.sv
sv/mma_datapath.sv
sv/matrix_multiply_accumulate.sv
sv/mma_checker.sv
dv/matrix_multiply_accumulate_tb.sv
